// ===== rtl/core/vfca_pkg.sv =====
// shared types, constants and helper functions for the voxel face cull / ao block
package vfca_pkg;

    localparam int DEF_CHUNK_X   = 16;
    localparam int DEF_CHUNK_Y   = 16;
    localparam int DEF_CHUNK_Z   = 16;
    localparam int DEF_TYPE_BITS = 8;
    localparam int CODE_W        = 16;   // widest stored type, codes are zero-extended to it

    localparam logic [3:0] SLOT_NORMAL = 4'd8;
    localparam logic [3:0] SLOT_CENTRE = 4'd9;

    localparam logic [1:0] REG_EMPTY  = 2'd0;
    localparam logic [1:0] REG_WATER  = 2'd1;
    localparam logic [1:0] REG_GLASS  = 2'd2;
    localparam logic [1:0] REG_LEAVES = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [4:0] pos_x;
        logic [4:0] pos_y;
        logic [4:0] pos_z;
        logic [7:0] voxel_type;
    } req_t;

    typedef struct packed {
        logic       face_valid;
        logic       water_face;
        logic [2:0] face_dir;
        logic [7:0] ao_bits;
        logic [1:0] tile_face;
        logic [5:0] tile_col;
        logic [3:0] tile_row;
        logic       last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CTR, ST_NBR, ST_SETTLE, ST_PICK, ST_PROBE, ST_PWAIT, ST_EMIT, ST_EMPTY
    } state_t;

    typedef struct packed {
        logic       acc_emit;
        logic       interior;
        logic [5:0] show_mask;
        logic       probe_need;
    } stat_t;

    typedef struct packed {
        logic       busy;
        logic       rd_en;
        logic [2:0] rd_face;
        logic [3:0] rd_slot;
        logic       emit;
        logic       emit_valid;
        logic [2:0] emit_face;
        logic       emit_last;
    } ctl_t;

    typedef struct packed {
        logic       cfg_valid;
        logic [7:0] code_empty;
        logic [7:0] code_water;
        logic [7:0] code_glass;
        logic [7:0] code_leaves;
    } codes_t;

    typedef struct packed {
        logic [7:0] empty_c;
        logic [7:0] water_c;
        logic [7:0] glass_c;
        logic [7:0] leaves_c;
    } code_set_t;

    // probe offsets plus one per axis, {dx, dy, dz}; slot 8 is the face normal, 9 the cell
    function automatic logic [5:0] probe_code(input logic [2:0] f, input logic [3:0] s);
        logic [5:0] c;
        c = 6'b010101;
        case ({f, s})
            {3'd0, 4'd0}: c = {2'd1, 2'd2, 2'd0};
            {3'd0, 4'd1}: c = {2'd2, 2'd2, 2'd1};
            {3'd0, 4'd2}: c = {2'd1, 2'd2, 2'd2};
            {3'd0, 4'd3}: c = {2'd0, 2'd2, 2'd1};
            {3'd0, 4'd4}: c = {2'd0, 2'd2, 2'd0};
            {3'd0, 4'd5}: c = {2'd2, 2'd2, 2'd0};
            {3'd0, 4'd6}: c = {2'd0, 2'd2, 2'd2};
            {3'd0, 4'd7}: c = {2'd2, 2'd2, 2'd2};
            {3'd0, 4'd8}: c = {2'd1, 2'd2, 2'd1};
            {3'd1, 4'd0}: c = {2'd1, 2'd2, 2'd2};
            {3'd1, 4'd1}: c = {2'd2, 2'd1, 2'd2};
            {3'd1, 4'd2}: c = {2'd1, 2'd0, 2'd2};
            {3'd1, 4'd3}: c = {2'd0, 2'd1, 2'd2};
            {3'd1, 4'd4}: c = {2'd0, 2'd2, 2'd2};
            {3'd1, 4'd5}: c = {2'd2, 2'd2, 2'd2};
            {3'd1, 4'd6}: c = {2'd0, 2'd0, 2'd2};
            {3'd1, 4'd7}: c = {2'd2, 2'd0, 2'd2};
            {3'd1, 4'd8}: c = {2'd1, 2'd1, 2'd2};
            {3'd2, 4'd0}: c = {2'd2, 2'd2, 2'd1};
            {3'd2, 4'd1}: c = {2'd2, 2'd1, 2'd0};
            {3'd2, 4'd2}: c = {2'd2, 2'd0, 2'd1};
            {3'd2, 4'd3}: c = {2'd2, 2'd1, 2'd2};
            {3'd2, 4'd4}: c = {2'd2, 2'd2, 2'd2};
            {3'd2, 4'd5}: c = {2'd2, 2'd2, 2'd0};
            {3'd2, 4'd6}: c = {2'd2, 2'd0, 2'd2};
            {3'd2, 4'd7}: c = {2'd2, 2'd0, 2'd0};
            {3'd2, 4'd8}: c = {2'd2, 2'd1, 2'd1};
            {3'd3, 4'd0}: c = {2'd1, 2'd2, 2'd0};
            {3'd3, 4'd1}: c = {2'd0, 2'd1, 2'd0};
            {3'd3, 4'd2}: c = {2'd1, 2'd0, 2'd0};
            {3'd3, 4'd3}: c = {2'd2, 2'd1, 2'd0};
            {3'd3, 4'd4}: c = {2'd2, 2'd2, 2'd0};
            {3'd3, 4'd5}: c = {2'd0, 2'd2, 2'd0};
            {3'd3, 4'd6}: c = {2'd2, 2'd0, 2'd0};
            {3'd3, 4'd7}: c = {2'd0, 2'd0, 2'd0};
            {3'd3, 4'd8}: c = {2'd1, 2'd1, 2'd0};
            {3'd4, 4'd0}: c = {2'd0, 2'd2, 2'd1};
            {3'd4, 4'd1}: c = {2'd0, 2'd1, 2'd2};
            {3'd4, 4'd2}: c = {2'd0, 2'd0, 2'd1};
            {3'd4, 4'd3}: c = {2'd0, 2'd1, 2'd0};
            {3'd4, 4'd4}: c = {2'd0, 2'd2, 2'd0};
            {3'd4, 4'd5}: c = {2'd0, 2'd2, 2'd2};
            {3'd4, 4'd6}: c = {2'd0, 2'd0, 2'd0};
            {3'd4, 4'd7}: c = {2'd0, 2'd0, 2'd2};
            {3'd4, 4'd8}: c = {2'd0, 2'd1, 2'd1};
            {3'd5, 4'd0}: c = {2'd1, 2'd0, 2'd0};
            {3'd5, 4'd1}: c = {2'd0, 2'd0, 2'd1};
            {3'd5, 4'd2}: c = {2'd1, 2'd0, 2'd2};
            {3'd5, 4'd3}: c = {2'd2, 2'd0, 2'd1};
            {3'd5, 4'd4}: c = {2'd2, 2'd0, 2'd0};
            {3'd5, 4'd5}: c = {2'd0, 2'd0, 2'd0};
            {3'd5, 4'd6}: c = {2'd2, 2'd0, 2'd2};
            {3'd5, 4'd7}: c = {2'd0, 2'd0, 2'd2};
            {3'd5, 4'd8}: c = {2'd1, 2'd0, 2'd1};
            default:      c = 6'b010101;
        endcase
        return c;
    endfunction

    function automatic logic is_clear(input logic [CODE_W-1:0] t, input code_set_t k);
        return t == CODE_W'(k.empty_c) || t == CODE_W'(k.water_c) ||
               t == CODE_W'(k.glass_c) || t == CODE_W'(k.leaves_c);
    endfunction

    function automatic logic occludes(input logic [CODE_W-1:0] t, input code_set_t k);
        return t != CODE_W'(k.empty_c) && t != CODE_W'(k.water_c) &&
               t != CODE_W'(k.glass_c);
    endfunction

    function automatic logic [1:0] corner_ao(input logic s1, input logic s2, input logic c);
        return {1'b0, s1} + {1'b0, s2} + {1'b0, c | (s1 & s2)};
    endfunction

endpackage

// ===== rtl/core/voxel_face_cull_ao_top.sv =====
// top level of the voxel face cull and ambient occlusion block
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------
//  request   | start, taken when !busy   | request (req_t)
//  result    | result_valid strobe       | result (res_t), no back-pressure
//  config    | cfg_we                    | cfg_index, cfg_data
//
//  a write request is taken while idle and leaves busy low
//  an emit reads the cell, its six face neighbours, then eight probes per shown
//  occluding face through the one memory port; with no face shown, or for a cell
//  outside the interior (which reads nothing), a single empty record is issued
//  each record strobes once, the cycle after it is formed; reset clears the
//  sequencer and loads the default type codes, not the voxel memory; no stalls
module voxel_face_cull_ao_top
    import vfca_pkg::*;
#(
    parameter int CHUNK_X   = DEF_CHUNK_X,
    parameter int CHUNK_Y   = DEF_CHUNK_Y,
    parameter int CHUNK_Z   = DEF_CHUNK_Z,
    parameter int TYPE_BITS = DEF_TYPE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vfca_pkg::req_t    request,
    output logic              result_valid,
    output vfca_pkg::res_t    result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    // padded volume geometry
    localparam int PX    = CHUNK_X + 2;
    localparam int PY    = CHUNK_Y + 2;
    localparam int PZ    = CHUNK_Z + 2;
    localparam int PYZ   = PY * PZ;
    localparam int DEPTH = PX * PYZ;
    localparam int AW    = $clog2(DEPTH);
    localparam int AWX   = AW + 2;
    localparam int BIAS  = PYZ + PZ + 1;

    stat_t          stat;
    ctl_t           ctl;
    code_set_t      codes_reg;
    logic           acc;
    logic           in_pad, interior;
    logic [AWX-1:0] in_base;
    logic [AWX-1:0] base_reg;
    logic [AWX-1:0] rd_addr;
    logic [5:0]     pc;
    logic [AWX-1:0] tx, ty, tz;
    logic           wr_en;
    logic [AW-1:0]  mem_addr;
    logic [TYPE_BITS-1:0] rdata;
    logic           tag_valid_reg;
    logic [2:0]     tag_face_reg;
    logic [3:0]     tag_slot_reg;
    logic [CODE_W-1:0] b_ext, nb_ext;
    logic [TYPE_BITS-1:0] b_reg;
    logic [5:0]     mask_reg;
    logic [7:0]     p_reg;
    logic           b_water, show, probe_need;
    logic [5:0]     hi6;
    res_t           rec;
    res_t           res_reg;
    logic           res_valid_reg;

    assign acc = start && !busy;

    // range checks on the padded coordinates
    assign in_pad   = (32'(request.pos_x) < PX) && (32'(request.pos_y) < PY) &&
                      (32'(request.pos_z) < PZ);
    assign interior = (request.pos_x != 5'd0) && (32'(request.pos_x) <= CHUNK_X) &&
                      (request.pos_y != 5'd0) && (32'(request.pos_y) <= CHUNK_Y) &&
                      (request.pos_z != 5'd0) && (32'(request.pos_z) <= CHUNK_Z);

    // linear address: constant multiplies only
    assign in_base = AWX'(request.pos_x) * AWX'(PYZ) + AWX'(request.pos_y) * AWX'(PZ) +
                     AWX'(request.pos_z);

    // shared address unit: cell base plus probe offset
    assign pc = probe_code(ctl.rd_face, ctl.rd_slot);
    assign tx = (pc[5:4] == 2'd2) ? AWX'(2 * PYZ) : (pc[5:4] == 2'd1) ? AWX'(PYZ) : '0;
    assign ty = (pc[3:2] == 2'd2) ? AWX'(2 * PZ) : (pc[3:2] == 2'd1) ? AWX'(PZ) : '0;
    assign tz = {{(AWX-2){1'b0}}, pc[1:0]};
    assign rd_addr = base_reg + tx + ty + tz - AWX'(BIAS);

    assign wr_en    = acc && !request.req_type && in_pad;
    assign mem_addr = wr_en ? in_base[AW-1:0] : rd_addr[AW-1:0];

    vfca_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (TYPE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .re    (ctl.rd_en),
        .addr  (mem_addr),
        .wdata (TYPE_BITS'(request.voxel_type)),
        .rdata (rdata)
    );

    assign stat.acc_emit   = acc && request.req_type;
    assign stat.interior   = interior;
    assign stat.show_mask  = mask_reg;
    assign stat.probe_need = probe_need;

    vfca_seq u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .stat (stat),
        .ctl  (ctl)
    );

    assign busy = ctl.busy;

    // cull decision on the arriving neighbour
    assign b_ext      = CODE_W'(b_reg);
    assign nb_ext     = CODE_W'(rdata);
    assign b_water    = (b_ext == CODE_W'(codes_reg.water_c));
    assign probe_need = !b_water && occludes(b_ext, codes_reg);

    always_comb
    begin
        if (b_ext == CODE_W'(codes_reg.empty_c))
        begin
            show = 1'b0;
        end
        else if (b_water)
        begin
            show = is_clear(nb_ext, codes_reg) && (nb_ext != CODE_W'(codes_reg.water_c));
        end
        else
        begin
            show = is_clear(nb_ext, codes_reg) &&
                   !(is_clear(b_ext, codes_reg) && (nb_ext == b_ext));
        end
    end

    // record assembly
    assign hi6 = 6'(b_ext >> 4);

    always_comb
    begin
        rec = '0;
        rec.last = ctl.emit_last;
        if (ctl.emit_valid)
        begin
            rec.face_valid = 1'b1;
            rec.water_face = b_water;
            rec.face_dir   = ctl.emit_face;
            if (probe_need)
            begin
                rec.ao_bits = {corner_ao(p_reg[1], p_reg[2], p_reg[7]),
                               corner_ao(p_reg[2], p_reg[3], p_reg[6]),
                               corner_ao(p_reg[0], p_reg[1], p_reg[5]),
                               corner_ao(p_reg[3], p_reg[0], p_reg[4])};
            end
            if (!b_water)
            begin
                rec.tile_face = (ctl.emit_face == 3'd5) ? 2'd2 :
                                (ctl.emit_face == 3'd0) ? 2'd0 : 2'd1;
                rec.tile_col  = 6'({2'b00, hi6} + {1'b0, hi6, 1'b0});
                rec.tile_row  = b_ext[3:0];
            end
        end
    end

    // control state: codes, read tag, face mask, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg     <= '{empty_c: 8'd0, water_c: 8'd1, glass_c: 8'd2, leaves_c: 8'd3};
            tag_valid_reg <= 1'b0;
            mask_reg      <= 6'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_EMPTY:  codes_reg.empty_c  <= cfg_data;
                    REG_WATER:  codes_reg.water_c  <= cfg_data;
                    REG_GLASS:  codes_reg.glass_c  <= cfg_data;
                    REG_LEAVES: codes_reg.leaves_c <= cfg_data;
                    default: ;
                endcase
            end
            tag_valid_reg <= ctl.rd_en;
            if (stat.acc_emit)
            begin
                mask_reg <= 6'd0;
            end
            else if (tag_valid_reg && tag_slot_reg == SLOT_NORMAL)
            begin
                mask_reg[tag_face_reg] <= show;
            end
            res_valid_reg <= ctl.emit;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tag_face_reg <= ctl.rd_face;
        tag_slot_reg <= ctl.rd_slot;
        if (stat.acc_emit)
        begin
            base_reg <= in_base;
        end
        if (tag_valid_reg && tag_slot_reg == SLOT_CENTRE)
        begin
            b_reg <= rdata;
        end
        if (tag_valid_reg && !tag_slot_reg[3])
        begin
            p_reg[tag_slot_reg[2:0]] <= occludes(nb_ext, codes_reg);
        end
        if (ctl.emit)
        begin
            res_reg <= rec;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // an emit request always turns busy on next cycle
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.req_type |=> busy)
        else $error("emit request not taken up");
    // an empty record always closes its request
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.face_valid |-> result.last)
        else $error("empty record without last");
    // water faces carry no occlusion and no tiles
    a_water_plain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.water_face |-> result.ao_bits == 8'd0 &&
        result.tile_col == 6'd0 && result.tile_row == 4'd0)
        else $error("water face with occlusion or tile");
    // the final record of a request leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy || $past(start))
        else $error("block still busy after final record");
endmodule

// ===== rtl/core/vfca_store.sv =====
// single-port voxel memory with registered read data
module vfca_store #(
    parameter int DEPTH = 5832,
    parameter int AW    = 13,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/vfca_seq.sv =====
// sequencer: centre and normal reads, face pick, probe reads and record issue
module vfca_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  vfca_pkg::stat_t stat,
    output vfca_pkg::ctl_t  ctl
);
    import vfca_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] face_reg, face_next;
    logic [5:0] done_reg, done_next;
    logic [5:0] rem;
    logic [5:0] rem_after;
    logic [2:0] low_face;
    logic       any_rem;

    assign rem       = stat.show_mask & ~done_reg;
    assign rem_after = rem & ~(6'd1 << face_reg);

    always_comb
    begin
        low_face = 3'd0;
        any_rem  = 1'b0;
        for (int i = 5; i >= 0; i--)
        begin
            if (rem[i])
            begin
                low_face = 3'(i);
                any_rem  = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        face_next  = face_reg;
        done_next  = done_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.acc_emit)
                begin
                    done_next  = 6'd0;
                    state_next = stat.interior ? ST_CTR : ST_EMPTY;
                end
            end
            ST_CTR:
            begin
                k_next     = 3'd0;
                state_next = ST_NBR;
            end
            ST_NBR:
            begin
                if (k_reg == 3'd5)
                begin
                    state_next = ST_SETTLE;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_SETTLE: state_next = ST_PICK;
            ST_PICK:
            begin
                k_next    = 3'd0;
                face_next = low_face;
                if (!any_rem)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    state_next = stat.probe_need ? ST_PROBE : ST_EMIT;
                end
            end
            ST_PROBE:
            begin
                if (k_reg == 3'd7)
                begin
                    state_next = ST_PWAIT;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_PWAIT:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                done_next  = done_reg | (6'd1 << face_reg);
                state_next = (rem_after == 6'd0) ? ST_IDLE : ST_PICK;
            end
            ST_EMPTY:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl            = '0;
        ctl.busy       = (state_reg != ST_IDLE);
        ctl.emit_face  = face_reg;
        ctl.rd_face    = face_reg;
        unique case (state_reg)
            ST_CTR:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = SLOT_CENTRE;
            end
            ST_NBR:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_face = k_reg;
                ctl.rd_slot = SLOT_NORMAL;
            end
            ST_PROBE:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = {1'b0, k_reg};
            end
            ST_EMIT:
            begin
                ctl.emit       = 1'b1;
                ctl.emit_valid = 1'b1;
                ctl.emit_last  = (rem_after == 6'd0);
            end
            ST_EMPTY:
            begin
                ctl.emit      = 1'b1;
                ctl.emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= 3'd0;
            face_reg  <= 3'd0;
            done_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            face_reg  <= face_next;
            done_reg  <= done_next;
        end
    end

    // a record is only issued for a face still pending
    a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> rem[face_reg])
        else $error("record issued for a face not pending");
    // probing only follows a pick
    a_probe_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_PROBE) |-> $past(state_reg) == ST_PICK)
        else $error("probe phase entered out of order");
    // the normal sweep always covers all six faces
    a_nbr_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SETTLE |-> $past(state_reg) == ST_NBR && $past(k_reg) == 3'd5)
        else $error("neighbour sweep cut short");
endmodule
